FILE: hdl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent basis package
// Shared types, constants and fixed-point helpers for the tangent basis unit.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DIV_STEPS   = 64 + FRAC_BITS;
    localparam int DIV_SKIP    = 33;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [31:0] q_t;

    localparam q_t SAT_MAX = 32'sh7fffffff;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
        logic signed [31:0] bitan_x;
        logic signed [31:0] bitan_y;
        logic signed [31:0] bitan_z;
        logic               degenerate;
        logic               last;
    } result_t;

    // One triangle as handed from the front to the back: saturated edge and
    // UV deltas plus the three corner normals (nrm[corner][axis]).
    typedef struct packed {
        q_t [2:0]      dp1;
        q_t [2:0]      dp2;
        q_t            du1;
        q_t            dv1;
        q_t            du2;
        q_t            dv2;
        q_t [2:0][2:0] nrm;
    } tri_rec_t;

    typedef struct packed {
        logic        start;
        logic        narrow;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [30:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    // Symmetric saturation to +/-(2^31-1).
    function automatic q_t sat64(input logic signed [63:0] x);
        q_t r;
        if (x > 64'sd2147483647)
            r = SAT_MAX;
        else if (x < -64'sd2147483647)
            r = -SAT_MAX;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] ext64(input q_t v);
        return 64'(v);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        logic [63:0] r;
        r = x[63] ? (~x + 64'd1) : x;
        return r;
    endfunction

endpackage

FILE: hdl/triangle_tangent_basis.sv
// Most of the time spent on a triangle is in the shared divider, which forms
// each tangent and bitangent component and each normalisation. The queue holds
// two triangles, so the front end keeps taking corners while the back end is
// busy, until the queue is full.
// Reset: asynchronous, active low; clears corner phase, queue and sequencer.
// ----------------------------------------------------------------------------
// Triangle tangent basis
// Per-triangle tangent and bitangent from UV deltas, orthonormalized per vertex.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vtx_valid,
    output logic              vtx_stall,
    input  ttb_pkg::vertex_t  vtx,
    output logic              res_valid,
    input  logic              res_stall,
    output ttb_pkg::result_t  res
);
    import ttb_pkg::*;

    logic     push;
    tri_rec_t push_rec;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    tri_rec_t q_data;

    ttb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx),
        .q_full    (q_full),
        .push      (push),
        .push_rec  (push_rec)
    );

    ttb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_rec),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .rd_data (q_data)
    );

    ttb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

FILE: hdl/ttb_front.sv
// ----------------------------------------------------------------------------
// Triangle tangent basis front end
// Holds the first two corners of each triangle and, on the third, forms the
// saturated edge and UV deltas and pushes one triangle record to the queue.
// ----------------------------------------------------------------------------
module ttb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vtx_valid,
    output logic               vtx_stall,
    input  ttb_pkg::vertex_t   vtx,
    input  logic               q_full,
    output logic               push,
    output ttb_pkg::tri_rec_t  push_rec
);
    import ttb_pkg::*;

    typedef enum logic [2:0] {
        CORNER0 = 3'b001,
        CORNER1 = 3'b010,
        CORNER2 = 3'b100
    } corner_t;

    corner_t phase_reg, phase_next;
    q_t      pos_reg [2][3];
    q_t      tex_reg [2][2];
    q_t      nrm_reg [2][3];
    logic    accept;
    logic    slot;
    q_t      vpos [3];
    q_t      vnrm [3];

    assign vtx_stall = (phase_reg == CORNER2) && q_full;
    assign accept    = vtx_valid && !vtx_stall;
    assign slot      = (phase_reg == CORNER1);

    always_comb
    begin
        vpos[0] = vtx.pos_x;
        vpos[1] = vtx.pos_y;
        vpos[2] = vtx.pos_z;
        vnrm[0] = vtx.norm_x;
        vnrm[1] = vtx.norm_y;
        vnrm[2] = vtx.norm_z;
    end

    always_comb
    begin
        phase_next = phase_reg;
        push       = 1'b0;
        unique case (phase_reg)
            CORNER0: if (accept) phase_next = CORNER1;
            CORNER1: if (accept) phase_next = CORNER2;
            CORNER2:
            begin
                if (accept)
                begin
                    phase_next = CORNER0;
                    push       = 1'b1;
                end
            end
            default: phase_next = CORNER0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            push_rec.dp1[i]    = sat64(ext64(pos_reg[1][i]) - ext64(pos_reg[0][i]));
            push_rec.dp2[i]    = sat64(ext64(vpos[i]) - ext64(pos_reg[0][i]));
            push_rec.nrm[0][i] = nrm_reg[0][i];
            push_rec.nrm[1][i] = nrm_reg[1][i];
            push_rec.nrm[2][i] = vnrm[i];
        end
        push_rec.du1 = sat64(ext64(tex_reg[1][0]) - ext64(tex_reg[0][0]));
        push_rec.dv1 = sat64(ext64(tex_reg[1][1]) - ext64(tex_reg[0][1]));
        push_rec.du2 = sat64(ext64(vtx.tex_u) - ext64(tex_reg[0][0]));
        push_rec.dv2 = sat64(ext64(vtx.tex_v) - ext64(tex_reg[0][1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= CORNER0;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg != CORNER2))
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[slot][i] <= vpos[i];
                nrm_reg[slot][i] <= vnrm[i];
            end
            tex_reg[slot][0] <= vtx.tex_u;
            tex_reg[slot][1] <= vtx.tex_v;
        end
    end

endmodule

FILE: hdl/ttb_queue.sv
// ----------------------------------------------------------------------------
// Triangle record queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ttb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ttb_pkg::tri_rec_t  wr_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output ttb_pkg::tri_rec_t  rd_data
);
    import ttb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tri_rec_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hdl/ttb_div.sv
// ----------------------------------------------------------------------------
// Iterative fractional divider
// Restoring divider, one quotient bit per cycle, computing
// (num << FRAC_BITS) / den on magnitudes, saturated to 2^31-1.
// ----------------------------------------------------------------------------
module ttb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ttb_pkg::div_req_t  req,
    output ttb_pkg::div_rsp_t  rsp
);
    import ttb_pkg::*;

    logic [63:0]          rem_reg;
    logic [63:0]          nsh_reg;
    logic [63:0]          den_reg;
    logic [30:0]          quo_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [63:0]          shifted;
    logic                 ge;

    // The remainder stays below the divisor (< 2^63), so the shift never
    // loses a bit.
    assign shifted = {rem_reg[62:0], nsh_reg[63]};
    assign ge      = (shifted >= den_reg);

    assign rsp.done = done_reg;
    assign rsp.quo  = ovf_reg ? 31'h7fffffff : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.narrow ? DIV_CNT_W'(DIV_STEPS - DIV_SKIP)
                                       : DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            // A narrow dividend has its top bits clear, so those steps are skipped.
            nsh_reg <= req.narrow ? {req.num[63-DIV_SKIP:0], {DIV_SKIP{1'b0}}} : req.num;
            den_reg <= req.den;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? shifted - den_reg : shifted;
            nsh_reg <= {nsh_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[29:0], ge};
            ovf_reg <= ovf_reg | quo_reg[30];
        end
    end

endmodule

FILE: hdl/ttb_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit floor square root of a 64-bit value.
// ----------------------------------------------------------------------------
module ttb_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  ttb_pkg::sqrt_req_t  req,
    output ttb_pkg::sqrt_rsp_t  rsp
);
    import ttb_pkg::*;

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        fits;

    assign trial    = res_reg + bit_reg;
    assign fits     = (x_reg >= trial);
    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

FILE: hdl/ttb_back.sv
// ----------------------------------------------------------------------------
// Triangle tangent basis back end
// Sequencer over three registered multiplier lanes, the shared divider and
// the square root unit. Produces three result beats per triangle.
// ----------------------------------------------------------------------------
module ttb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ttb_pkg::tri_rec_t  q_data,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output ttb_pkg::result_t   res
);
    import ttb_pkg::*;

    typedef enum logic [21:0] {
        B_IDLE   = 22'h000001,
        B_DET_M  = 22'h000002,
        B_DET_A  = 22'h000004,
        B_NUM_M  = 22'h000008,
        B_NUM_A  = 22'h000010,
        B_DIV    = 22'h000020,
        B_DIV_W  = 22'h000040,
        B_DOT_M  = 22'h000080,
        B_DOT_A  = 22'h000100,
        B_PRJ_M  = 22'h000200,
        B_PRJ_A  = 22'h000400,
        B_LEN_M  = 22'h000800,
        B_LEN_A  = 22'h001000,
        B_SQRT_W = 22'h002000,
        B_NRM    = 22'h004000,
        B_NRM_W  = 22'h008000,
        B_CRS_M1 = 22'h010000,
        B_CRS_M2 = 22'h020000,
        B_CRS_A  = 22'h040000,
        B_HND_M  = 22'h080000,
        B_HND_A  = 22'h100000,
        B_EMIT   = 22'h200000
    } bstate_t;

    bstate_t            state_reg, state_next;
    tri_rec_t           rec_reg;
    logic signed [63:0] det_reg;
    logic signed [63:0] num_reg;
    q_t                 t_reg [3];
    q_t                 b_reg [3];
    q_t                 d_reg;
    q_t                 u_reg [3];
    logic [31:0]        len_reg;
    q_t                 o_reg [3];
    logic signed [63:0] xa_reg [3];
    q_t                 c_reg [3];
    logic signed [63:0] prod_reg [3];
    logic [1:0]         axis_reg;
    logic               isb_reg;
    logic [1:0]         corner_reg;
    logic               neg_reg;
    logic               dg_reg;
    logic               tdg_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    q_t                 ma [3];
    q_t                 mb [3];
    q_t                 nsel [3];
    logic signed [63:0] det_sum;
    logic signed [63:0] hnd_sum;
    logic [63:0]        len2;
    logic               out_free;
    logic               emit;
    q_t                 qval;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    sqrt_req_t          sqrt_req;
    sqrt_rsp_t          sqrt_rsp;
    result_t            res_new;

    ttb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ttb_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign emit      = (state_reg == B_EMIT) && out_free;
    assign pop       = (state_reg == B_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign det_sum = prod_reg[0] - prod_reg[1];
    assign hnd_sum = (prod_reg[0] >>> 2) + (prod_reg[1] >>> 2) + (prod_reg[2] >>> 2);
    assign len2    = $unsigned(prod_reg[0]) + $unsigned(prod_reg[1])
                   + $unsigned(prod_reg[2]);
    assign qval    = q_t'({1'b0, div_rsp.quo});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            nsel[i] = rec_reg.nrm[corner_reg][i];
    end

    // Operand selection for the three multiplier lanes.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma[i] = '0;
            mb[i] = '0;
        end
        unique case (state_reg)
            B_DET_M:
            begin
                ma[0] = rec_reg.du1;
                mb[0] = rec_reg.dv2;
                ma[1] = rec_reg.dv1;
                mb[1] = rec_reg.du2;
            end
            B_NUM_M:
            begin
                if (!isb_reg)
                begin
                    ma[0] = rec_reg.dp1[axis_reg];
                    mb[0] = rec_reg.dv2;
                    ma[1] = rec_reg.dp2[axis_reg];
                    mb[1] = rec_reg.dv1;
                end
                else
                begin
                    ma[0] = rec_reg.dp2[axis_reg];
                    mb[0] = rec_reg.du1;
                    ma[1] = rec_reg.dp1[axis_reg];
                    mb[1] = rec_reg.du2;
                end
            end
            B_DOT_M:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = nsel[i];
                    mb[i] = t_reg[i];
                end
            end
            B_PRJ_M:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = nsel[i];
                    mb[i] = d_reg;
                end
            end
            B_LEN_M:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = u_reg[i];
                    mb[i] = u_reg[i];
                end
            end
            B_CRS_M1:
            begin
                ma[0] = nsel[1];
                mb[0] = o_reg[2];
                ma[1] = nsel[2];
                mb[1] = o_reg[0];
                ma[2] = nsel[0];
                mb[2] = o_reg[1];
            end
            B_CRS_M2:
            begin
                ma[0] = nsel[2];
                mb[0] = o_reg[1];
                ma[1] = nsel[0];
                mb[1] = o_reg[2];
                ma[2] = nsel[1];
                mb[2] = o_reg[0];
            end
            B_HND_M:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = c_reg[i];
                    mb[i] = b_reg[i];
                end
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = '0;
                    mb[i] = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        div_req.start   = (state_reg == B_DIV) || (state_reg == B_NRM);
        div_req.narrow  = (state_reg == B_NRM);
        div_req.num     = (state_reg == B_NRM) ? mag64(ext64(u_reg[axis_reg]))
                                               : mag64(num_reg);
        div_req.den     = (state_reg == B_NRM) ? {32'd0, len_reg} : mag64(det_reg);
        sqrt_req.start    = (state_reg == B_LEN_A) && (len2 != '0);
        sqrt_req.radicand = len2;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (q_valid) state_next = B_DET_M;
            B_DET_M:  state_next = B_DET_A;
            B_DET_A:  state_next = (det_sum == '0) ? B_EMIT : B_NUM_M;
            B_NUM_M:  state_next = B_NUM_A;
            B_NUM_A:  state_next = B_DIV;
            B_DIV:    state_next = B_DIV_W;
            B_DIV_W:
            begin
                if (div_rsp.done)
                begin
                    if (isb_reg && (axis_reg == 2'd2))
                        state_next = B_DOT_M;
                    else
                        state_next = B_NUM_M;
                end
            end
            B_DOT_M:  state_next = B_DOT_A;
            B_DOT_A:  state_next = B_PRJ_M;
            B_PRJ_M:  state_next = B_PRJ_A;
            B_PRJ_A:  state_next = B_LEN_M;
            B_LEN_M:  state_next = B_LEN_A;
            B_LEN_A:  state_next = (len2 == '0) ? B_EMIT : B_SQRT_W;
            B_SQRT_W: if (sqrt_rsp.done) state_next = B_NRM;
            B_NRM:    state_next = B_NRM_W;
            B_NRM_W:
            begin
                if (div_rsp.done)
                    state_next = (axis_reg == 2'd2) ? B_CRS_M1 : B_NRM;
            end
            B_CRS_M1: state_next = B_CRS_M2;
            B_CRS_M2: state_next = B_CRS_A;
            B_CRS_A:  state_next = B_HND_M;
            B_HND_M:  state_next = B_HND_A;
            B_HND_A:  state_next = B_EMIT;
            B_EMIT:
            begin
                if (out_free)
                begin
                    if (corner_reg == 2'd2)
                        state_next = B_IDLE;
                    else if (tdg_reg)
                        state_next = B_EMIT;
                    else
                        state_next = B_DOT_M;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        res_new.degenerate = tdg_reg || dg_reg;
        res_new.last       = (corner_reg == 2'd2);
        if (tdg_reg || dg_reg)
        begin
            res_new.tan_x   = '0;
            res_new.tan_y   = '0;
            res_new.tan_z   = '0;
            res_new.bitan_x = '0;
            res_new.bitan_y = '0;
            res_new.bitan_z = '0;
        end
        else
        begin
            res_new.tan_x   = neg_reg ? -o_reg[0] : o_reg[0];
            res_new.tan_y   = neg_reg ? -o_reg[1] : o_reg[1];
            res_new.tan_z   = neg_reg ? -o_reg[2] : o_reg[2];
            res_new.bitan_x = b_reg[0];
            res_new.bitan_y = b_reg[1];
            res_new.bitan_z = b_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
            axis_reg      <= '0;
            isb_reg       <= 1'b0;
            corner_reg    <= '0;
            tdg_reg       <= 1'b0;
            dg_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                B_DET_A:
                begin
                    axis_reg   <= '0;
                    isb_reg    <= 1'b0;
                    corner_reg <= '0;
                    tdg_reg    <= (det_sum == '0);
                end
                B_DIV_W:
                begin
                    if (div_rsp.done)
                    begin
                        isb_reg <= !isb_reg;
                        if (isb_reg)
                            axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                end
                B_LEN_A:  dg_reg <= (len2 == '0);
                B_SQRT_W: if (sqrt_rsp.done) axis_reg <= '0;
                B_NRM_W:
                begin
                    if (div_rsp.done)
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                end
                B_EMIT:   if (out_free) corner_reg <= corner_reg + 2'd1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= ext64(ma[i]) * ext64(mb[i]);
        if (pop)
            rec_reg <= q_data;
        if (state_reg == B_DET_A)
            det_reg <= det_sum;
        if (state_reg == B_NUM_A)
            num_reg <= det_sum;
        if ((state_reg == B_DIV_W) && div_rsp.done)
        begin
            if (num_reg[63] != det_reg[63])
            begin
                if (isb_reg)
                    b_reg[axis_reg] <= -qval;
                else
                    t_reg[axis_reg] <= -qval;
            end
            else
            begin
                if (isb_reg)
                    b_reg[axis_reg] <= qval;
                else
                    t_reg[axis_reg] <= qval;
            end
        end
        if (state_reg == B_DOT_A)
            d_reg <= sat64((prod_reg[0] >>> FRAC_BITS) + (prod_reg[1] >>> FRAC_BITS)
                           + (prod_reg[2] >>> FRAC_BITS));
        if (state_reg == B_PRJ_A)
        begin
            for (int i = 0; i < 3; i++)
                u_reg[i] <= sat64(ext64(t_reg[i]) - (prod_reg[i] >>> FRAC_BITS));
        end
        if ((state_reg == B_SQRT_W) && sqrt_rsp.done)
            len_reg <= sqrt_rsp.root;
        if ((state_reg == B_NRM_W) && div_rsp.done)
            o_reg[axis_reg] <= u_reg[axis_reg][31] ? -qval : qval;
        if (state_reg == B_CRS_M2)
        begin
            for (int i = 0; i < 3; i++)
                xa_reg[i] <= prod_reg[i];
        end
        if (state_reg == B_CRS_A)
        begin
            for (int i = 0; i < 3; i++)
                c_reg[i] <= sat64((xa_reg[i] - prod_reg[i]) >>> FRAC_BITS);
        end
        if (state_reg == B_HND_A)
            neg_reg <= hnd_sum[63];
        if (emit)
            res_reg <= res_new;
    end

endmodule

FILE: hdl/ttb_checker.sv
// ----------------------------------------------------------------------------
// Triangle tangent basis checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module ttb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              vtx_valid,
    input logic              vtx_stall,
    input ttb_pkg::vertex_t  vtx,
    input logic              res_valid,
    input logic              res_stall,
    input ttb_pkg::result_t  res
);
    import ttb_pkg::*;

    // A stalled vertex beat stays offered and unchanged.
    a_vtx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_stall |=> vtx_valid && $stable(vtx))
        else $error("vertex beat changed while stalled");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("result beat changed while stalled");

    // A degenerate beat carries zero vectors.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.degenerate |-> (res.tan_x == 0) && (res.tan_y == 0)
            && (res.tan_z == 0) && (res.bitan_x == 0) && (res.bitan_y == 0)
            && (res.bitan_z == 0))
        else $error("degenerate beat with nonzero vectors");

    // A normalized tangent component never exceeds one.
    a_tan_unit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.tan_x <= 32'sd65536) && (res.tan_x >= -32'sd65536)
            && (res.tan_y <= 32'sd65536) && (res.tan_y >= -32'sd65536)
            && (res.tan_z <= 32'sd65536) && (res.tan_z >= -32'sd65536))
        else $error("tangent component out of unit range");

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Triangle tangent basis testbench
// Streams triangle-list vertices through the unit, predicts the tangent,
// bitangent and flags of each result beat, and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
    import ttb_pkg::*;

    localparam int NUM_RANDOM  = 186;
    localparam longint CYCLE_LIMIT = 64'd2000000;

    logic    clk;
    logic    rst_n;
    logic    vtx_valid;
    logic    vtx_stall;
    vertex_t vtx;
    logic    res_valid;
    logic    res_stall;
    result_t res;

    triangle_tangent_basis u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor state: the two held corners of the triangle in progress.
    vertex_t held_corner [2];
    int      corner_idx;
    result_t expected_beats [$];
    int      error_count = 0;
    longint  cycle_count = 0;
    int      send_idle_pct;
    int      recv_stall_pct;

    localparam longint SMAX = 64'sd2147483647;

    function automatic longint clamp31(input longint x);
        if (x > SMAX)
            return SMAX;
        if (x < -SMAX)
            return -SMAX;
        return x;
    endfunction

    function automatic logic [63:0] magnitude(input longint x);
        return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    // Restoring division of (n << FRAC_BITS) by d, quotient capped at 2^31-1.
    function automatic logic [63:0] shifted_quotient(input logic [63:0] n,
                                                     input logic [63:0] d);
        logic [63:0] r;
        logic [63:0] q;
        logic        b;
        r = 0;
        q = 0;
        for (int k = 0; k < 64 + FRAC_BITS; k++)
        begin
            b = k < 64 ? n[63 - k] : 1'b0;
            r = {r[62:0], b};
            q = q << 1;
            if (q > (64'd1 << 40))
                q = 64'd1 << 40;
            if (r >= d)
            begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return q > 64'(SMAX) ? 64'(SMAX) : q;
    endfunction

    function automatic longint signed_quotient(input longint num, input longint den);
        longint q;
        q = longint'(shifted_quotient(magnitude(num), magnitude(den)));
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Orthonormalizes the triangle tangent against one corner normal.
    function automatic logic corner_basis(input longint nv [3], input longint tv [3],
                                          input longint bv [3], output longint ov [3]);
        longint      d;
        longint      uv [3];
        longint      cv [3];
        longint      s;
        logic [63:0] len2;
        logic [63:0] len;
        logic [63:0] m;
        d = 0;
        s = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++)
            d += (nv[i] * tv[i]) >>> FRAC_BITS;
        d = clamp31(d);
        for (int i = 0; i < 3; i++)
        begin
            uv[i] = clamp31(tv[i] - ((nv[i] * d) >>> FRAC_BITS));
            len2 += magnitude(uv[i]) * magnitude(uv[i]);
        end
        if (len2 == 0)
        begin
            ov = '{0, 0, 0};
            return 1'b1;
        end
        len = int_sqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            m = (magnitude(uv[i]) << FRAC_BITS) / len;
            ov[i] = uv[i] < 0 ? -longint'(m) : longint'(m);
        end
        cv[0] = clamp31((nv[1] * ov[2] - nv[2] * ov[1]) >>> FRAC_BITS);
        cv[1] = clamp31((nv[2] * ov[0] - nv[0] * ov[2]) >>> FRAC_BITS);
        cv[2] = clamp31((nv[0] * ov[1] - nv[1] * ov[0]) >>> FRAC_BITS);
        for (int i = 0; i < 3; i++)
            s += (cv[i] * bv[i]) >>> 2;
        if (s < 0)
            for (int i = 0; i < 3; i++)
                ov[i] = -ov[i];
        return 1'b0;
    endfunction

    // Consumes one vertex beat; on the third corner queues three result beats.
    task automatic predict_tangent_basis(input vertex_t v);
        vertex_t c [3];
        longint  p [3][3];
        longint  nm [3][3];
        longint  tu [3];
        longint  tvv [3];
        longint  dp1 [3];
        longint  dp2 [3];
        longint  du1, dv1, du2, dv2, det;
        longint  tt [3];
        longint  bb [3];
        longint  nv [3];
        longint  ov [3];
        logic    degen;
        result_t r;
        if (corner_idx < 2)
        begin
            held_corner[corner_idx] = v;
            corner_idx++;
            return;
        end
        corner_idx = 0;
        c[0] = held_corner[0];
        c[1] = held_corner[1];
        c[2] = v;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = '{c[k].pos_x, c[k].pos_y, c[k].pos_z};
            nm[k] = '{c[k].norm_x, c[k].norm_y, c[k].norm_z};
            tu[k] = c[k].tex_u;
            tvv[k] = c[k].tex_v;
        end
        for (int i = 0; i < 3; i++)
        begin
            dp1[i] = clamp31(p[1][i] - p[0][i]);
            dp2[i] = clamp31(p[2][i] - p[0][i]);
        end
        du1 = clamp31(tu[1] - tu[0]);
        dv1 = clamp31(tvv[1] - tvv[0]);
        du2 = clamp31(tu[2] - tu[0]);
        dv2 = clamp31(tvv[2] - tvv[0]);
        det = du1 * dv2 - dv1 * du2;
        tt = '{0, 0, 0};
        bb = '{0, 0, 0};
        if (det != 0)
            for (int i = 0; i < 3; i++)
            begin
                tt[i] = signed_quotient(dp1[i] * dv2 - dp2[i] * dv1, det);
                bb[i] = signed_quotient(dp2[i] * du1 - dp1[i] * du2, det);
            end
        for (int k = 0; k < 3; k++)
        begin
            ov = '{0, 0, 0};
            degen = (det == 0);
            if (!degen)
            begin
                nv = nm[k];
                degen = corner_basis(nv, tt, bb, ov);
            end
            r.tan_x = degen ? '0 : 32'(ov[0]);
            r.tan_y = degen ? '0 : 32'(ov[1]);
            r.tan_z = degen ? '0 : 32'(ov[2]);
            r.bitan_x = degen ? '0 : 32'(bb[0]);
            r.bitan_y = degen ? '0 : 32'(bb[1]);
            r.bitan_z = degen ? '0 : 32'(bb[2]);
            r.degenerate = degen;
            r.last = (k == 2);
            expected_beats = {expected_beats, r};
        end
    endtask

    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    // Directed vertex table. Rows 0..2 form a simple unit triangle whose result
    // is known: T = +x, B = +y, normal +z. Rows after that are predicted.
    localparam int NUM_DIRECTED = 24;
    vertex_t directed_rows [NUM_DIRECTED];
    result_t unit_expect [3];
    int      unit_expect_used = 0;

    initial
    begin
        // unit triangle in the xy plane
        directed_rows[0] = '{0, 0, 0, 0, 0, 0, 0, ONE};
        directed_rows[1] = '{ONE, 0, 0, ONE, 0, 0, 0, ONE};
        directed_rows[2] = '{0, ONE, 0, 0, ONE, 0, 0, ONE};
        // zero UV determinant: all UVs equal
        directed_rows[3] = '{0, 0, 0, ONE, ONE, 0, 0, ONE};
        directed_rows[4] = '{ONE, 0, 0, ONE, ONE, 0, 0, ONE};
        directed_rows[5] = '{0, ONE, 0, ONE, ONE, 0, 0, ONE};
        // tangent parallel to the normal: zero length after projection
        directed_rows[6] = '{0, 0, 0, 0, 0, ONE, 0, 0};
        directed_rows[7] = '{ONE, 0, 0, ONE, 0, ONE, 0, 0};
        directed_rows[8] = '{0, ONE, 0, 0, ONE, ONE, 0, 0};
        // extreme positions and UVs: deltas and quotients saturate
        directed_rows[9]  = '{QMIN, QMIN, QMIN, QMIN, 0, 0, 0, ONE};
        directed_rows[10] = '{QMAX, QMAX, QMAX, QMAX, 1, 0, 0, ONE};
        directed_rows[11] = '{QMAX, QMIN, QMAX, 0, QMAX, ONE, 0, 0};
        // tiny determinant with large edges
        directed_rows[12] = '{0, 0, 0, 0, 0, 0, ONE, 0};
        directed_rows[13] = '{QMAX, 32'sh4000_0000, QMIN, 1, 0, 0, ONE, 0};
        directed_rows[14] = '{QMIN, QMAX, 5, 0, 1, 0, -ONE, 0};
        // mirrored UVs: flipped handedness
        directed_rows[15] = '{0, 0, 0, ONE, 0, 0, 0, ONE};
        directed_rows[16] = '{ONE, 0, 0, 0, 0, 0, 0, ONE};
        directed_rows[17] = '{0, ONE, 0, ONE, ONE, 0, 0, ONE};
        // extreme normals
        directed_rows[18] = '{0, 0, 0, 0, 0, QMAX, QMIN, QMAX};
        directed_rows[19] = '{ONE, 3, -7, ONE, 0, QMIN, QMAX, QMIN};
        directed_rows[20] = '{-ONE, ONE, 9, 0, ONE, -1, -1, -1};
        directed_rows[21] = '{-1, -1, -1, -1, -1, 0, 0, 0};
        directed_rows[22] = '{1, 2, 3, QMAX, QMIN, 0, 0, 0};
        directed_rows[23] = '{QMIN, QMAX, 0, QMIN, QMAX, 0, 0, 0};
        unit_expect[0] = '{ONE, 0, 0, 0, ONE, 0, 1'b0, 1'b0};
        unit_expect[1] = '{ONE, 0, 0, 0, ONE, 0, 1'b0, 1'b0};
        unit_expect[2] = '{ONE, 0, 0, 0, ONE, 0, 1'b0, 1'b1};
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return QMAX;
            2: return QMIN;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        logic signed [31:0] n [3];
        v.pos_x = rand_q();
        v.pos_y = rand_q();
        v.pos_z = rand_q();
        v.tex_u = rand_q();
        v.tex_v = rand_q();
        if ($urandom_range(0, 3) != 0)
        begin
            // near-unit normal along a random axis with small jitter
            n = '{$signed($urandom_range(0, 4000)) - 2000,
                  $signed($urandom_range(0, 4000)) - 2000,
                  $signed($urandom_range(0, 4000)) - 2000};
            n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? ONE : -ONE;
            v.norm_x = n[0];
            v.norm_y = n[1];
            v.norm_z = n[2];
        end
        else
        begin
            v.norm_x = rand_q();
            v.norm_y = rand_q();
            v.norm_z = rand_q();
        end
        return v;
    endfunction

    // Valid stays high from one accepted beat to the next unless the sender idles.
    task automatic send_vertex(input vertex_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            vtx_valid <= 1'b0;
            @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx <= v;
        @(posedge clk);
        while (vtx_stall)
            @(posedge clk);
        predict_tangent_basis(v);
    endtask

    // Receiver: random stall, compare accepted beats in order.
    always @(posedge clk)
    begin
        result_t e;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    error_count++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    // The unit triangle is checked against its known result.
                    if (unit_expect_used < 3)
                    begin
                        e = unit_expect[unit_expect_used];
                        unit_expect_used++;
                    end
                    if (res.tan_x !== e.tan_x)
                    begin
                        $error("tan_x expected %0d actual %0d", e.tan_x, res.tan_x);
                        error_count++;
                    end
                    if (res.tan_y !== e.tan_y)
                    begin
                        $error("tan_y expected %0d actual %0d", e.tan_y, res.tan_y);
                        error_count++;
                    end
                    if (res.tan_z !== e.tan_z)
                    begin
                        $error("tan_z expected %0d actual %0d", e.tan_z, res.tan_z);
                        error_count++;
                    end
                    if (res.bitan_x !== e.bitan_x)
                    begin
                        $error("bitan_x expected %0d actual %0d", e.bitan_x, res.bitan_x);
                        error_count++;
                    end
                    if (res.bitan_y !== e.bitan_y)
                    begin
                        $error("bitan_y expected %0d actual %0d", e.bitan_y, res.bitan_y);
                        error_count++;
                    end
                    if (res.bitan_z !== e.bitan_z)
                    begin
                        $error("bitan_z expected %0d actual %0d", e.bitan_z, res.bitan_z);
                        error_count++;
                    end
                    if (res.degenerate !== e.degenerate)
                    begin
                        $error("degenerate expected %0b actual %0b",
                               e.degenerate, res.degenerate);
                        error_count++;
                    end
                    if (res.last !== e.last)
                    begin
                        $error("last expected %0b actual %0b", e.last, res.last);
                        error_count++;
                    end
                end
            end
            res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int drain;
        rst_n = 1'b0;
        vtx_valid = 1'b0;
        vtx = '0;
        corner_idx = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_vertex(directed_rows[i]);
        vtx_valid <= 1'b0;

        // Hold off until the unit has drained completely.
        while (expected_beats.size() != 0)
            @(posedge clk);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            case ((i / 12) % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            send_vertex(rand_vertex());
        end
        // Complete any partial triangle so every corner produces a beat.
        while (corner_idx != 0)
            send_vertex(rand_vertex());
        vtx_valid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 1200)
        begin
            @(posedge clk);
            drain++;
        end
        if (error_count == 0 && expected_beats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: files.f
hdl/ttb_pkg.sv
hdl/ttb_front.sv
hdl/ttb_queue.sv
hdl/ttb_div.sv
hdl/ttb_sqrt.sv
hdl/ttb_back.sv
hdl/triangle_tangent_basis.sv
hdl/ttb_checker.sv
tb/testbench.sv
